FILE: rtl/stream_byte_reassembler_defines.svh
// Assertion macros used by the property checker in rtl/sbr_checker.sv.
`ifndef STREAM_BYTE_REASSEMBLER_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SBR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in stream byte reassembler");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in stream byte reassembler");

`endif

FILE: rtl/sbr_pkg.sv
`default_nettype none

package sbr_pkg;

	typedef struct packed {
		logic [63:0] byte_index;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last_segment;
		logic [63:0] stream_end_index;
		logic [6:0]  stream_buffered;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_closed;
		logic [6:0] held_bytes;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/sbr_slot_add.sv
`default_nettype none

// Modular adder over the circular window: slot = (base + step) mod CAPACITY.
module sbr_slot_add #(
	parameter int CAPACITY = 64,
	parameter int HW = 6
) (
	input  logic [HW-1:0] base,
	input  logic [HW-1:0] step,
	output logic [HW-1:0] slot
);

	localparam logic [HW:0] CAP_W = (HW+1)'(CAPACITY);

	logic [HW:0] sum;

	always_comb begin
		sum = {1'b0, base} + {1'b0, step};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		slot = sum[HW-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/sbr_mem.sv
`default_nettype none

// Byte store for the window, one write and one registered read per cycle.
module sbr_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/stream_byte_reassembler.sv
`default_nettype none

// Channel   Handshake                   Payload
// input     start, busy (start & !busy) item   (sbr_pkg::item_t)
// result    result_strobe, one cycle    result (sbr_pkg::result_t)
//
// An item passes through insert, a scan of the present flags, one slot per cycle through
// the shared slot adder, and a check; a released run then comes out one beat per cycle
// from the byte store. An item that releases nothing gives one status result instead;
// on a closed stream it goes straight from insert to that status result.
// Reset clears the present flags, counters and end record at once; no clearing pass.
// Results cannot be held off; busy stays high until the last beat of an item is out.
module stream_byte_reassembler
	import sbr_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_strobe,
	output result_t result
);

	localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_INSERT = 6'b000010,
		S_SCAN   = 6'b000100,
		S_CHECK  = 6'b001000,
		S_EMIT   = 6'b010000,
		S_STAT   = 6'b100000
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [CAPACITY-1:0] present_q;
	logic [HW-1:0]       head_q;
	logic [CW-1:0]       held_q;
	logic [63:0]         emitted_q;
	logic                end_known_q;
	logic [63:0]         end_pos_q;
	logic                closed_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       remain_q;

	logic [7:0]    used;
	logic [7:0]    win;
	logic [63:0]   offset;
	logic          in_win;
	logic [HW-1:0] step;
	logic [HW-1:0] slot;
	logic          scan_hit;
	logic [63:0]   end_sum;
	logic          we;
	logic [7:0]    rdata;

	always_comb begin
		used = 8'(item_q.stream_buffered) + 8'(held_q);
		win = (used >= 8'(CAPACITY)) ? 8'd0 : 8'(CAPACITY) - used;
		offset = item_q.byte_index - emitted_q;
		in_win = item_q.has_byte && (item_q.byte_index >= emitted_q) && (offset < 64'(win));
	end

	// The one slot adder serves the insert, the scan and the read address.
	always_comb begin
		case (state_q)
			S_INSERT: step = offset[HW-1:0];
			S_SCAN:   step = cnt_q[HW-1:0];
			S_EMIT:   step = HW'(1);
			default:  step = '0;
		endcase
	end

	sbr_slot_add #(
		.CAPACITY(CAPACITY),
		.HW(HW)
	) u_slot (
		.base(head_q),
		.step(step),
		.slot(slot)
	);

	assign scan_hit = (cnt_q < CW'(CAPACITY)) && present_q[slot];
	assign end_sum = emitted_q + 64'(cnt_q);
	assign we = (state_q == S_INSERT) && !closed_q && in_win && !present_q[slot];

	sbr_mem #(
		.DEPTH(CAPACITY),
		.AW(HW)
	) u_mem (
		.clk(clk),
		.we(we),
		.waddr(slot),
		.wdata(item_q.data_byte),
		.raddr(slot),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			present_q <= '0;
			head_q <= '0;
			held_q <= '0;
			emitted_q <= '0;
			end_known_q <= 1'b0;
			end_pos_q <= '0;
			closed_q <= 1'b0;
			cnt_q <= '0;
			remain_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						// The end record updates even on a closed stream.
						if (item.last_segment) begin
							end_known_q <= 1'b1;
							end_pos_q <= item.stream_end_index;
						end
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					if (closed_q) begin
						state_q <= S_STAT;
					end else begin
						if (we) begin
							present_q[slot] <= 1'b1;
							held_q <= held_q + CW'(1);
						end
						cnt_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Every beat of the run carries the count and flag left after it.
					held_q <= held_q - cnt_q;
					remain_q <= cnt_q;
					if (end_known_q && (end_sum == end_pos_q)) begin
						closed_q <= 1'b1;
					end
					state_q <= (cnt_q == '0) ? S_STAT : S_EMIT;
				end
				S_EMIT: begin
					present_q[head_q] <= 1'b0;
					head_q <= slot;
					emitted_q <= emitted_q + 64'd1;
					remain_q <= remain_q - CW'(1);
					if (remain_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_STAT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign result_strobe = (state_q == S_EMIT) || (state_q == S_STAT);

	always_comb begin
		result.out_byte = (state_q == S_EMIT) ? rdata : 8'd0;
		result.byte_valid = (state_q == S_EMIT);
		result.run_last = (state_q == S_STAT) || (remain_q == CW'(1));
		result.stream_closed = closed_q;
		result.held_bytes = 7'(held_q);
	end

endmodule

`default_nettype wire

FILE: rtl/sbr_checker.sv
`default_nettype none

`include "stream_byte_reassembler_defines.svh"

module sbr_props
	import sbr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_strobe,
	input result_t result
);

	// Results only come out while an item is in work.
	`SBR_ASSERT_SAME(a_strobe_busy, result_strobe, busy)
	// An accepted beat always starts a busy period.
	`SBR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// A status-only result is always the single result of its item.
	`SBR_ASSERT_SAME(a_status_last, result_strobe && !result.byte_valid, result.run_last)
	// After the last result of an item no further result follows directly.
	`SBR_ASSERT_NEXT(a_last_gap, result_strobe && result.run_last, !result_strobe)

endmodule

bind stream_byte_reassembler sbr_props u_sbr_props (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result_strobe(result_strobe),
	.result(result)
);

`default_nettype wire

FILE: verif/sbr_checker.sv
`default_nettype none

module sbr_checker
	import sbr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    result_strobe,
	input  result_t result,
	output int      mismatches,
	output int      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 64;

	logic [7:0]  slot_data [CAP];
	logic        slot_full [CAP];
	int unsigned head;
	logic [6:0]  held;
	logic [63:0] delivered;
	logic        end_seen;
	logic [63:0] end_at;
	logic        closed;

	result_t     expected_beats [$];
	result_t     want;
	int          bad;

	// Applies one accepted item to the shadow window and queues the beats it releases, or one status beat.
	task automatic reassemble(input item_t it);
		int unsigned used;
		int unsigned room;
		int unsigned s;
		logic [63:0] off;
		result_t     beats [$];
		result_t     r;
		if (it.last_segment) begin
			end_seen = 1'b1;
			end_at = it.stream_end_index;
		end
		if (!closed) begin
			used = it.stream_buffered + held;
			room = (used >= CAP) ? 0 : CAP - used;
			if (it.has_byte && it.byte_index >= delivered) begin
				off = it.byte_index - delivered;
				if (off < room) begin
					s = (head + int'(off)) % CAP;
					if (!slot_full[s]) begin
						slot_full[s] = 1'b1;
						slot_data[s] = it.data_byte;
						held++;
					end
				end
			end
			while (beats.size() < CAP && slot_full[head]) begin
				r = '0;
				r.out_byte = slot_data[head];
				r.byte_valid = 1'b1;
				beats.push_back(r);
				slot_full[head] = 1'b0;
				head = (head + 1) % CAP;
				if (held > 0)
					held--;
				delivered++;
			end
			if (end_seen && delivered == end_at)
				closed = 1'b1;
		end
		if (beats.size() == 0)
			beats.push_back('0);
		foreach (beats[k]) begin
			beats[k].run_last = (k == beats.size() - 1);
			beats[k].stream_closed = closed;
			beats[k].held_bytes = held;
			expected_beats.push_back(beats[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP; i++) begin
				slot_full[i] = 1'b0;
				slot_data[i] = '0;
			end
			head = 0;
			held = '0;
			delivered = '0;
			end_seen = 1'b0;
			end_at = '0;
			closed = 1'b0;
			expected_beats.delete();
			bad = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Results are checked before a new item is applied on the same edge.
			if (result_strobe) begin
				if (expected_beats.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected beat: byte=%02h valid=%b last=%b closed=%b pending=%0d",
							result.out_byte, result.byte_valid, result.run_last,
							result.stream_closed, result.held_bytes);
				end else begin
					want = expected_beats.pop_front();
					if (result.out_byte !== want.out_byte ||
							result.byte_valid !== want.byte_valid ||
							result.run_last !== want.run_last ||
							result.stream_closed !== want.stream_closed ||
							result.held_bytes !== want.held_bytes) begin
						bad++;
						if (bad <= 10)
							$display("beat mismatch: expected byte=%02h valid=%b last=%b",
								want.out_byte, want.byte_valid, want.run_last,
								" closed=%b pending=%0d,", want.stream_closed,
								want.held_bytes,
								" got byte=%02h valid=%b last=%b", result.out_byte,
								result.byte_valid, result.run_last,
								" closed=%b pending=%0d", result.stream_closed,
								result.held_bytes);
					end
				end
			end
			if (start && !busy)
				reassemble(item);
			mismatches <= bad;
			outstanding <= expected_beats.size();
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
	import sbr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_strobe;
	result_t result;
	int      mismatches;
	int      outstanding;

	int          cycle_count;
	int          burst_left;
	int          sent;
	logic [63:0] base;

	stream_byte_reassembler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result)
	);

	sbr_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[stream_byte_reassembler] ERROR");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t mk_item(logic [63:0] idx, logic [7:0] d, logic has, logic last,
			logic [63:0] end_i, logic [6:0] buffered);
		item_t it;
		it.byte_index = idx;
		it.data_byte = d;
		it.has_byte = has;
		it.last_segment = last;
		it.stream_end_index = end_i;
		it.stream_buffered = buffered;
		return it;
	endfunction

	// Offers one beat and holds it until accepted; the sender pauses between bursts.
	task automatic send_beat(input item_t it);
		int gap;
		item <= it;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Sends the k bytes at base in shuffled order, or in reverse for a full window, so that
	// they collect out of order before the first one releases the run. A broken pass sends
	// a random subset under random downstream pressure first; the clean pass keeps the free
	// window wide enough that every byte of the segment lands.
	task automatic send_segment(input int k, input bit broken, input bit closing,
			input logic [63:0] end_i);
		int order [64];
		int t;
		int tmp;
		int limit;
		for (int j = 0; j < k; j++)
			order[j] = (k == 64) ? 63 - j : j;
		if (k < 64) begin
			for (int j = k - 1; j > 0; j--) begin
				t = $urandom_range(0, j);
				tmp = order[j];
				order[j] = order[t];
				order[t] = tmp;
			end
		end
		if (broken) begin
			for (int j = 0; j < k; j++)
				if ($urandom_range(0, 3) != 0)
					send_beat(mk_item(base + order[j], 8'($urandom), 1'b1, 1'b0, rand64(),
						7'($urandom_range(0, 64))));
		end
		limit = 62 - 2 * k;
		if (limit < 0)
			limit = 0;
		for (int j = 0; j < k; j++) begin
			send_beat(mk_item(base + order[j], 8'($urandom), 1'b1, closing,
				closing ? end_i : rand64(), 7'($urandom_range(0, limit))));
			if ($urandom_range(0, 6) == 0)
				send_beat(mk_item(base + order[$urandom_range(0, j)], 8'($urandom), 1'b1,
					closing, closing ? end_i : rand64(), 7'($urandom_range(0, limit))));
			if (!closing && $urandom_range(0, 9) == 0)
				send_beat(mk_item(base + $urandom_range(0, 63), 8'($urandom), 1'b0, 1'b0,
					rand64(), 7'($urandom_range(0, 64))));
		end
		base += k;
	endtask

	initial begin
		int big_done;
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		sent = 0;
		big_done = 0;
		burst_left = $urandom_range(1, 12);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: markers, out-of-order hold, duplicates, overload, window edges, end record.
		send_beat(mk_item(64'd0, 8'h00, 1'b0, 1'b0, '0, 7'd0));
		send_beat(mk_item(64'd1, 8'hA5, 1'b1, 1'b0, '0, 7'd0));
		send_beat(mk_item(64'd1, 8'h5A, 1'b1, 1'b0, '0, 7'd0));
		send_beat(mk_item(64'd0, 8'h00, 1'b1, 1'b0, '1, 7'd0));
		send_beat(mk_item(64'd2, 8'hFF, 1'b1, 1'b0, '0, 7'd64));
		send_beat(mk_item(64'd2, 8'h3C, 1'b1, 1'b0, '0, 7'd63));
		send_beat(mk_item(64'd67, 8'hFF, 1'b1, 1'b0, '0, 7'd0));
		send_beat(mk_item(64'd66, 8'h81, 1'b1, 1'b0, '0, 7'd0));
		send_beat(mk_item(64'd1, 8'h11, 1'b1, 1'b0, '0, 7'd0));
		send_beat(mk_item('1, 8'hC3, 1'b1, 1'b0, '1, 7'd0));
		// An end below the delivered count can never be reached.
		send_beat(mk_item(64'd3, 8'h22, 1'b0, 1'b1, 64'd1, 7'd0));
		send_beat(mk_item(64'd3, 8'h33, 1'b1, 1'b0, '0, 7'd64));
		send_beat(mk_item(64'd3, 8'h7E, 1'b1, 1'b1, '1, 7'd0));
		send_beat(mk_item(64'd5, 8'h44, 1'b1, 1'b0, '0, 7'd62));
		send_beat(mk_item(64'd4, 8'h55, 1'b1, 1'b0, '0, 7'd62));
		base = 64'd5;
		sent = 0;

		while (sent < 280) begin
			k = $urandom_range(0, 99);
			if (k < 8 && big_done < 3 && base > 64'd66) begin
				send_segment(64, 1'b0, 1'b0, '0);
				big_done++;
			end else if (k < 70) begin
				send_segment($urandom_range(1, 16), $urandom_range(0, 3) == 0, 1'b0, '0);
			end else begin
				case ($urandom_range(0, 4))
					0: send_beat(mk_item(base + 64 + $urandom_range(0, 1000), 8'($urandom),
						1'b1, 1'b0, rand64(), 7'($urandom_range(0, 64))));
					1: send_beat(mk_item(rand64(), 8'($urandom), 1'b1, 1'b0, rand64(),
						7'($urandom_range(0, 64))));
					2: send_beat(mk_item(base - 1 - (rand64() % base), 8'($urandom), 1'b1,
						1'b0, rand64(), 7'($urandom_range(0, 64))));
					3: send_beat(mk_item(base + $urandom_range(0, 63), 8'($urandom), 1'b0,
						1'b0, rand64(), 7'($urandom_range(0, 64))));
					default: send_beat(mk_item(base + 64 + $urandom_range(0, 1000),
						8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
						$urandom_range(0, 1) ? base - 1 - (rand64() % base)
							: base + 64'd1000000 + $urandom,
						7'($urandom_range(0, 64))));
				endcase
			end
		end

		// The final segment carries the real end, then a few beats hit the closed stream.
		k = $urandom_range(1, 8);
		send_segment(k, 1'b0, 1'b1, base + k);
		send_beat(mk_item(base, 8'($urandom), 1'b1, 1'b0, rand64(), 7'd0));
		send_beat(mk_item(base + 1, 8'($urandom), 1'b1, 1'b1, rand64(),
			7'($urandom_range(0, 64))));
		send_beat(mk_item(base, 8'($urandom), 1'b0, 1'b1, base, 7'd0));
		send_beat(mk_item(rand64(), 8'($urandom), 1'b1, 1'b0, rand64(),
			7'($urandom_range(0, 64))));

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[stream_byte_reassembler] OK");
		else
			$display("[stream_byte_reassembler] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
